[rtl/core/tbs_pkg.sv]
// shared types and constants for the token bucket shaper
package tbs_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int TOKEN_WIDTH_DEFAULT = 16;

   localparam int ID_WIDTH    = 16;
   localparam int LEVEL_WIDTH = 16;
   localparam int QLEN_WIDTH  = 5;
   localparam int TOTAL_WIDTH = 32;

   localparam int CAPACITY_RESET = 10;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_ENQUEUE = 1'b1;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

[rtl/core/token_bucket_shaper.sv]
// token bucket shaper: top level
// A word is taken when start is high and busy is low; busy then stays high for one
// cycle while the head entry of the packet queue, read from its memory at the accept
// edge, is combined with the bucket level. The result word is written into the
// result registers at the edge that ends that cycle and appears on the rsp_ ports
// with rsp_valid high for exactly one cycle: there is no back-pressure on the
// result side. No new word is accepted while busy is high, so each word is done
// before the next is taken. The bucket capacity is written over the csr_ port, which
// is always ready, and should be changed only while no word is in flight.
module token_bucket_shaper import tbs_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int TOKEN_WIDTH = TOKEN_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_command,
   input  logic [ID_WIDTH-1:0]    req_packet_id,
   input  logic [LEVEL_WIDTH-1:0] req_tokens_needed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LEVEL_WIDTH-1:0] csr_data,
   output logic                   rsp_valid,
   output logic [LEVEL_WIDTH-1:0] rsp_bucket_level,
   output logic                   rsp_token_was_dropped,
   output logic                   rsp_released,
   output logic [ID_WIDTH-1:0]    rsp_released_id,
   output logic [LEVEL_WIDTH-1:0] rsp_released_need,
   output logic                   rsp_enqueue_rejected,
   output logic [QLEN_WIDTH-1:0]  rsp_queue_length,
   output logic [TOTAL_WIDTH-1:0] rsp_arrived_total,
   output logic [TOTAL_WIDTH-1:0] rsp_dropped_total
);

   ctrl_cmd_type cmd;

   tbs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   tbs_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TOKEN_WIDTH (TOKEN_WIDTH)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_command           (req_command),
      .req_packet_id         (req_packet_id),
      .req_tokens_needed     (req_tokens_needed),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data),
      .rsp_valid             (rsp_valid),
      .rsp_bucket_level      (rsp_bucket_level),
      .rsp_token_was_dropped (rsp_token_was_dropped),
      .rsp_released          (rsp_released),
      .rsp_released_id       (rsp_released_id),
      .rsp_released_need     (rsp_released_need),
      .rsp_enqueue_rejected  (rsp_enqueue_rejected),
      .rsp_queue_length      (rsp_queue_length),
      .rsp_arrived_total     (rsp_arrived_total),
      .rsp_dropped_total     (rsp_dropped_total)
   );

endmodule

[rtl/core/tbs_ram.sv]
// generic single write port ram with registered read
module tbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tbs_ctrl.sv]
// sequencing state machine for the token bucket shaper
module tbs_ctrl import tbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy     = (state_ff != ST_IDLE);
   assign cmd.load = start && (state_ff == ST_IDLE);
   assign cmd.exec = (state_ff == ST_EXEC);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_single_exec: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one execute cycle");

endmodule

[rtl/core/tbs_dpath.sv]
// bucket, packet queue, counters and result registers
module tbs_dpath import tbs_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int TOKEN_WIDTH = TOKEN_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   input  logic                   req_command,
   input  logic [ID_WIDTH-1:0]    req_packet_id,
   input  logic [LEVEL_WIDTH-1:0] req_tokens_needed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LEVEL_WIDTH-1:0] csr_data,
   output logic                   rsp_valid,
   output logic [LEVEL_WIDTH-1:0] rsp_bucket_level,
   output logic                   rsp_token_was_dropped,
   output logic                   rsp_released,
   output logic [ID_WIDTH-1:0]    rsp_released_id,
   output logic [LEVEL_WIDTH-1:0] rsp_released_need,
   output logic                   rsp_enqueue_rejected,
   output logic [QLEN_WIDTH-1:0]  rsp_queue_length,
   output logic [TOTAL_WIDTH-1:0] rsp_arrived_total,
   output logic [TOTAL_WIDTH-1:0] rsp_dropped_total
);

   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_WIDTH = ID_WIDTH + TOKEN_WIDTH;
   localparam logic [PTR_WIDTH-1:0] LAST_SLOT = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL  = CNT_WIDTH'(QUEUE_DEPTH);

   logic [TOKEN_WIDTH-1:0] capacity_ff, capacity_in;
   logic [TOKEN_WIDTH-1:0] level_ff, level_in;
   logic [PTR_WIDTH-1:0]   head_ff, head_in;
   logic [PTR_WIDTH-1:0]   tail_ff, tail_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [TOTAL_WIDTH-1:0] arrived_ff, arrived_in;
   logic [TOTAL_WIDTH-1:0] dropped_ff, dropped_in;

   logic                   command_ff;
   logic [ID_WIDTH-1:0]    id_ff;
   logic [TOKEN_WIDTH-1:0] need_ff;

   logic                   rsp_valid_ff;
   logic [LEVEL_WIDTH-1:0] rsp_level_ff;
   logic                   rsp_drop_ff, rsp_drop_in;
   logic                   rsp_rel_ff, rsp_rel_in;
   logic [ID_WIDTH-1:0]    rsp_rel_id_ff, rsp_rel_id_in;
   logic [LEVEL_WIDTH-1:0] rsp_rel_need_ff, rsp_rel_need_in;
   logic                   rsp_rej_ff, rsp_rej_in;
   logic [QLEN_WIDTH-1:0]  rsp_qlen_ff;
   logic [TOTAL_WIDTH-1:0] rsp_arrived_ff, rsp_dropped_ff;

   logic [ENTRY_WIDTH-1:0] head_entry;
   logic [ID_WIDTH-1:0]    head_id;
   logic [TOKEN_WIDTH-1:0] head_need;
   logic [TOKEN_WIDTH-1:0] level_up;
   logic                   ram_wr_en;

   tbs_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data ({id_ff, need_ff}),
      .rd_en   (cmd.load),
      .rd_addr (head_ff),
      .rd_data (head_entry)
   );

   assign head_id   = head_entry[ENTRY_WIDTH-1:TOKEN_WIDTH];
   assign head_need = head_entry[TOKEN_WIDTH-1:0];

   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? TOKEN_WIDTH'(csr_data) : capacity_ff;

   always_comb begin
      level_in        = level_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      arrived_in      = arrived_ff;
      dropped_in      = dropped_ff;
      level_up        = level_ff;
      ram_wr_en       = 1'b0;
      rsp_drop_in     = 1'b0;
      rsp_rel_in      = 1'b0;
      rsp_rel_id_in   = '0;
      rsp_rel_need_in = '0;
      rsp_rej_in      = 1'b0;
      if (cmd.exec) begin
         case (command_ff)
            CMD_TICK: begin
               arrived_in = arrived_ff + 32'd1;
               if (level_ff < capacity_ff) begin
                  level_up = level_ff + TOKEN_WIDTH'(1);
               end else begin
                  rsp_drop_in = 1'b1;
                  dropped_in  = dropped_ff + 32'd1;
               end
               level_in = level_up;
               if ((count_ff != '0) && (head_need <= level_up)) begin
                  level_in        = level_up - head_need;
                  rsp_rel_in      = 1'b1;
                  rsp_rel_id_in   = head_id;
                  rsp_rel_need_in = LEVEL_WIDTH'(head_need);
                  head_in         = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_WIDTH'(1);
                  count_in        = count_ff - CNT_WIDTH'(1);
               end
            end
            CMD_ENQUEUE: begin
               if ((count_ff == CNT_FULL) || (need_ff > capacity_ff)) begin
                  rsp_rej_in = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  tail_in   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PTR_WIDTH'(1);
                  count_in  = count_ff + CNT_WIDTH'(1);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= TOKEN_WIDTH'(CAPACITY_RESET);
         level_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         arrived_ff   <= '0;
         dropped_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         level_ff     <= level_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         arrived_ff   <= arrived_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= cmd.exec;
      end
   end

   // captured request word and result word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         id_ff      <= req_packet_id;
         need_ff    <= TOKEN_WIDTH'(req_tokens_needed);
      end
      if (cmd.exec) begin
         rsp_level_ff    <= LEVEL_WIDTH'(level_in);
         rsp_drop_ff     <= rsp_drop_in;
         rsp_rel_ff      <= rsp_rel_in;
         rsp_rel_id_ff   <= rsp_rel_id_in;
         rsp_rel_need_ff <= rsp_rel_need_in;
         rsp_rej_ff      <= rsp_rej_in;
         rsp_qlen_ff     <= QLEN_WIDTH'(count_in);
         rsp_arrived_ff  <= arrived_in;
         rsp_dropped_ff  <= dropped_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_bucket_level      = rsp_level_ff;
   assign rsp_token_was_dropped = rsp_drop_ff;
   assign rsp_released          = rsp_rel_ff;
   assign rsp_released_id       = rsp_rel_id_ff;
   assign rsp_released_need     = rsp_rel_need_ff;
   assign rsp_enqueue_rejected  = rsp_rej_ff;
   assign rsp_queue_length      = rsp_qlen_ff;
   assign rsp_arrived_total     = rsp_arrived_ff;
   assign rsp_dropped_total     = rsp_dropped_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_result_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> (rsp_valid && !(rsp_released && rsp_enqueue_rejected)))
      else $error("missing or inconsistent result word");

endmodule

[bench/shaper_tb_pkg.sv]
`timescale 1ns / 100ps
// token bucket predictor and result scoreboard for the shaper testbench
package shaper_tb_pkg;
   import tbs_pkg::*;

   typedef struct {
      logic [LEVEL_WIDTH-1:0] bucket_level;
      logic                   token_was_dropped;
      logic                   released;
      logic [ID_WIDTH-1:0]    released_id;
      logic [LEVEL_WIDTH-1:0] released_need;
      logic                   enqueue_rejected;
      logic [QLEN_WIDTH-1:0]  queue_length;
      logic [TOTAL_WIDTH-1:0] arrived_total;
      logic [TOTAL_WIDTH-1:0] dropped_total;
   } shaper_word_type;

   class shaper_scoreboard_type;
      logic [LEVEL_WIDTH-1:0] capacity;
      logic [LEVEL_WIDTH-1:0] level;
      logic [ID_WIDTH-1:0]    queued_ids[$];
      logic [LEVEL_WIDTH-1:0] queued_needs[$];
      logic [TOTAL_WIDTH-1:0] arrived;
      logic [TOTAL_WIDTH-1:0] dropped;
      shaper_word_type        expected_words[$];
      int                     fail_count;

      function new();
         capacity   = LEVEL_WIDTH'(CAPACITY_RESET);
         level      = '0;
         arrived    = '0;
         dropped    = '0;
         fail_count = 0;
      endfunction

      function void set_capacity(logic [LEVEL_WIDTH-1:0] value);
         capacity = value;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function int waiting();
         return queued_ids.size();
      endfunction

      // work out the result word of one accepted input word
      function void note_word(logic command, logic [ID_WIDTH-1:0] packet_id,
                              logic [LEVEL_WIDTH-1:0] need);
         shaper_word_type w;
         w = '{default: '0};
         if (command == CMD_TICK) begin
            if (level < capacity) begin
               level = level + 1'b1;
            end else begin
               w.token_was_dropped = 1'b1;
               dropped = dropped + 1'b1;
            end
            arrived = arrived + 1'b1;
            if (queued_needs.size() != 0 && queued_needs[0] <= level) begin
               level = level - queued_needs[0];
               w.released      = 1'b1;
               w.released_id   = queued_ids.pop_front();
               w.released_need = queued_needs.pop_front();
            end
         end else if (queued_ids.size() >= QUEUE_DEPTH_DEFAULT || need > capacity) begin
            w.enqueue_rejected = 1'b1;
         end else begin
            queued_ids.push_back(packet_id);
            queued_needs.push_back(need);
         end
         w.bucket_level  = level;
         w.queue_length  = QLEN_WIDTH'(queued_ids.size());
         w.arrived_total = arrived;
         w.dropped_total = dropped;
         expected_words.push_back(w);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_word(shaper_word_type got);
         shaper_word_type want;
         if (expected_words.size() == 0) begin
            $error("result word arrived with none expected");
            fail_count++;
            return;
         end
         want = expected_words.pop_front();
         compare_field("bucket_level", want.bucket_level, got.bucket_level);
         compare_field("token_was_dropped", want.token_was_dropped, got.token_was_dropped);
         compare_field("released", want.released, got.released);
         compare_field("released_id", want.released_id, got.released_id);
         compare_field("released_need", want.released_need, got.released_need);
         compare_field("enqueue_rejected", want.enqueue_rejected, got.enqueue_rejected);
         compare_field("queue_length", want.queue_length, got.queue_length);
         compare_field("arrived_total", want.arrived_total, got.arrived_total);
         compare_field("dropped_total", want.dropped_total, got.dropped_total);
      endfunction
   endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 100ps
// top of the token bucket shaper testbench: clock, reset, drivers and result monitor
module tb_top;
   import tbs_pkg::*;
   import shaper_tb_pkg::*;

   logic                   clock;
   logic                   reset             = 1'b1;
   logic                   start             = 1'b0;
   logic                   busy;
   logic                   req_command       = CMD_TICK;
   logic [ID_WIDTH-1:0]    req_packet_id     = '0;
   logic [LEVEL_WIDTH-1:0] req_tokens_needed = '0;
   logic                   csr_valid         = 1'b0;
   logic                   csr_ready;
   logic [LEVEL_WIDTH-1:0] csr_data          = '0;
   logic                   rsp_valid;
   logic [LEVEL_WIDTH-1:0] rsp_bucket_level;
   logic                   rsp_token_was_dropped;
   logic                   rsp_released;
   logic [ID_WIDTH-1:0]    rsp_released_id;
   logic [LEVEL_WIDTH-1:0] rsp_released_need;
   logic                   rsp_enqueue_rejected;
   logic [QLEN_WIDTH-1:0]  rsp_queue_length;
   logic [TOTAL_WIDTH-1:0] rsp_arrived_total;
   logic [TOTAL_WIDTH-1:0] rsp_dropped_total;

   shaper_scoreboard_type board;
   int                    calm_left = 0;

   token_bucket_shaper u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_packet_id         (req_packet_id),
      .req_tokens_needed     (req_tokens_needed),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data),
      .rsp_valid             (rsp_valid),
      .rsp_bucket_level      (rsp_bucket_level),
      .rsp_token_was_dropped (rsp_token_was_dropped),
      .rsp_released          (rsp_released),
      .rsp_released_id       (rsp_released_id),
      .rsp_released_need     (rsp_released_need),
      .rsp_enqueue_rejected  (rsp_enqueue_rejected),
      .rsp_queue_length      (rsp_queue_length),
      .rsp_arrived_total     (rsp_arrived_total),
      .rsp_dropped_total     (rsp_dropped_total)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         board.check_word('{bucket_level:      rsp_bucket_level,
                            token_was_dropped: rsp_token_was_dropped,
                            released:          rsp_released,
                            released_id:       rsp_released_id,
                            released_need:     rsp_released_need,
                            enqueue_rejected:  rsp_enqueue_rejected,
                            queue_length:      rsp_queue_length,
                            arrived_total:     rsp_arrived_total,
                            dropped_total:     rsp_dropped_total});
      end
   end

   task automatic issue_word(input logic command, input logic [ID_WIDTH-1:0] packet_id,
                             input logic [LEVEL_WIDTH-1:0] need);
      int idle;
      if (calm_left > 0) begin
         calm_left--;
         idle = 0;
      end else begin
         idle = $urandom_range(0, 12);
         if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(5, 25);
      end
      start             <= 1'b1;
      req_command       <= command;
      req_packet_id     <= packet_id;
      req_tokens_needed <= need;
      do @(posedge clock); while (busy);
      board.note_word(command, packet_id, need);
      if (idle > 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic tick();
      issue_word(CMD_TICK, ID_WIDTH'($urandom), LEVEL_WIDTH'($urandom));
   endtask

   task automatic enqueue(input logic [ID_WIDTH-1:0] packet_id,
                          input logic [LEVEL_WIDTH-1:0] need);
      issue_word(CMD_ENQUEUE, packet_id, need);
   endtask

   // hold off until every result word is in and the pipeline is quiet
   task automatic settle();
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [LEVEL_WIDTH-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_capacity(value);
      csr_valid <= 1'b0;
   endtask

   task automatic empty_queue();
      int guard;
      guard = 0;
      while (board.waiting() != 0 && guard < 300) begin
         tick();
         guard++;
      end
   endtask

   task automatic random_item(input int tick_pct);
      logic [LEVEL_WIDTH-1:0] need;
      int                     cap;
      int                     pick;
      cap = int'(board.capacity);
      if ($urandom_range(0, 99) < tick_pct) begin
         tick();
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            need = LEVEL_WIDTH'($urandom_range(1, cap < 6 ? cap : 6));
         end else if (pick < 87) begin
            need = LEVEL_WIDTH'($urandom_range(1, cap < 64 ? cap : 64));
         end else if (pick < 95) begin
            need = (cap == 16'hFFFF) ? 16'd1 : LEVEL_WIDTH'(cap + 1);
         end else begin
            need = (cap == 16'hFFFF) ? LEVEL_WIDTH'($urandom_range(1, 6))
                                     : LEVEL_WIDTH'($urandom);
         end
         enqueue(ID_WIDTH'($urandom), need);
      end
   endtask

   initial begin
      int                     tick_pct;
      logic [LEVEL_WIDTH-1:0] phase_caps[6];
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // fill the bucket from empty, then overflow it
      repeat (11) tick();
      enqueue(16'h0000, 16'd1);
      enqueue(16'hFFFF, 16'd10);
      enqueue(16'h1234, 16'd11);
      enqueue(16'h5A5A, 16'hFFFF);
      tick();
      // capacity below the current level
      write_capacity(16'd3);
      tick();
      tick();
      enqueue(16'hA5A5, 16'd4);

      phase_caps = '{16'hFFFF, 16'd200, 16'd1, 16'd10, 16'd3, 16'd1};
      phase_caps[2] = LEVEL_WIDTH'($urandom_range(2, 30));
      foreach (phase_caps[p]) begin
         write_capacity(phase_caps[p]);
         for (int n = 0; n < 125; n++) begin
            if (n % 25 == 0) begin
               case ($urandom_range(0, 2))
                  0: tick_pct = 25;
                  1: tick_pct = 50;
                  default: tick_pct = 80;
               endcase
            end
            random_item(tick_pct);
         end
         empty_queue();
      end

      settle();
      if (board.fail_count == 0 && board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/tbs_pkg.sv
rtl/core/tbs_ram.sv
rtl/core/tbs_ctrl.sv
rtl/core/tbs_dpath.sv
rtl/core/token_bucket_shaper.sv
bench/shaper_tb_pkg.sv
bench/tb_top.sv
